[rtl/core/tpc_pkg.sv]
// ----------------------------------------------------------------------------
// tpc_pkg - shared definitions for the track particle classifier
// Point layout, command, class and status codes, and the angle bin helper.
// ----------------------------------------------------------------------------
package tpc_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int BIN_W       = 7;
   localparam int VAL_W       = 16;

   // floor(angle / 1000) as a multiply by 2^26/1000 rounded up, exact for 16 bits
   localparam logic [16:0] BIN_RECIP = 17'd67109;
   localparam int          BIN_SHIFT = 26;

   localparam logic signed [16:0] MOM_LIMIT   = 17'sd7000;
   localparam logic signed [16:0] MOM_MISSING = 17'sd100;

   localparam logic [1:0] CMD_LOAD     = 2'd0;
   localparam logic [1:0] CMD_CLEAR    = 2'd1;
   localparam logic [1:0] CMD_CLASSIFY = 2'd2;

   localparam logic [1:0] CLASS_NONE   = 2'd0;
   localparam logic [1:0] CLASS_MUON   = 2'd1;
   localparam logic [1:0] CLASS_PION   = 2'd2;
   localparam logic [1:0] CLASS_PROTON = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic             valid;
      logic [BIN_W-1:0] bin;
      logic [VAL_W-1:0] mom;
      logic [VAL_W-1:0] thr;
   } point_type;

   typedef struct packed {
      logic shift;
      logic wr;
      logic clr;
   } cell_ctl_type;

   typedef struct packed {
      logic start;
      logic step;
   } scan_ctl_type;

   typedef struct packed {
      logic       dup;
      logic [1:0] cls;
   } scan_res_type;

   function automatic logic [BIN_W-1:0] bin_of(input logic [VAL_W-1:0] angle);
      logic [32:0] prod;
      prod = 33'(angle) * 33'(BIN_RECIP);
      return BIN_W'(prod >> BIN_SHIFT);
   endfunction

endpackage

[rtl/core/tpc_cell.sv]
// ----------------------------------------------------------------------------
// tpc_cell - one threshold point of the table ring
// Holds a point; neighbour's on shift, new one on write, invalid on clear.
// ----------------------------------------------------------------------------
module tpc_cell
   import tpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  point_type    shift_in,
   input  point_type    wr_point,
   output point_type    point
);

   point_type point_ff;
   point_type point_in;

   always_comb begin
      point_in = point_ff;
      if (ctl.clr) begin
         point_in.valid = 1'b0;
      end else if (ctl.wr) begin
         point_in = wr_point;
      end else if (ctl.shift) begin
         point_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
      if (reset) begin
         point_ff.valid <= 1'b0;
      end
   end

   assign point = point_ff;

endmodule

[rtl/core/tpc_scan.sv]
// ----------------------------------------------------------------------------
// tpc_scan - running search over the points leaving the head of the ring
// Tracks the nearest bin at or above the query and the top bin, with momentum
// neighbours for each, plus a duplicate flag for loads.
// ----------------------------------------------------------------------------
module tpc_scan
   import tpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  scan_ctl_type     ctl,
   input  point_type        point,
   input  logic [BIN_W-1:0] q_bin,
   input  logic [VAL_W-1:0] q_mom,
   input  logic [VAL_W-1:0] q_vph,
   output scan_res_type     res
);

   typedef struct packed {
      logic             have;
      logic [BIN_W-1:0] bin;
      logic             lo_have;
      logic [VAL_W-1:0] lo_m;
      logic [VAL_W-1:0] lo_t;
      logic             hi_have;
      logic [VAL_W-1:0] hi_m;
      logic [VAL_W-1:0] hi_t;
   } nb_type;

   nb_type ge_ff, ge_in, mx_ff, mx_in, pick;
   logic   dup_ff, dup_in;
   logic [VAL_W-1:0] lo_d, hi_d, thr;

   // fold one point of the tracked bin into the lower / upper neighbour
   function automatic nb_type fold(input nb_type a, input point_type p,
                                   input logic [VAL_W-1:0] qm);
      nb_type r;
      r = a;
      if (p.mom <= qm) begin
         if (!a.lo_have || p.mom > a.lo_m) begin
            r.lo_have = 1'b1;
            r.lo_m    = p.mom;
            r.lo_t    = p.thr;
         end
      end else if (!a.hi_have || p.mom < a.hi_m) begin
         r.hi_have = 1'b1;
         r.hi_m    = p.mom;
         r.hi_t    = p.thr;
      end
      return r;
   endfunction

   function automatic nb_type fresh(input point_type p, input logic [VAL_W-1:0] qm);
      nb_type r;
      r      = '0;
      r.have = 1'b1;
      r.bin  = p.bin;
      return fold(r, p, qm);
   endfunction

   always_comb begin
      ge_in  = ge_ff;
      mx_in  = mx_ff;
      dup_in = dup_ff;
      if (ctl.start) begin
         ge_in  = '0;
         mx_in  = '0;
         dup_in = 1'b0;
      end else if (ctl.step && point.valid) begin
         if (point.bin >= q_bin) begin
            if (!ge_ff.have || point.bin < ge_ff.bin) begin
               ge_in = fresh(point, q_mom);
            end else if (point.bin == ge_ff.bin) begin
               ge_in = fold(ge_ff, point, q_mom);
            end
         end
         if (!mx_ff.have || point.bin > mx_ff.bin) begin
            mx_in = fresh(point, q_mom);
         end else if (point.bin == mx_ff.bin) begin
            mx_in = fold(mx_ff, point, q_mom);
         end
         if (point.bin == q_bin && point.mom == q_mom) begin
            dup_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ge_ff  <= ge_in;
      mx_ff  <= mx_in;
      dup_ff <= dup_in;
      if (reset) begin
         ge_ff.have <= 1'b0;
         mx_ff.have <= 1'b0;
         dup_ff     <= 1'b0;
      end
   end

   // nearest neighbour, a tie goes to the upper point
   always_comb begin
      pick = ge_ff.have ? ge_ff : mx_ff;
      lo_d = q_mom - pick.lo_m;
      hi_d = pick.hi_m - q_mom;
      if (pick.lo_have && pick.hi_have) begin
         thr = (lo_d < hi_d) ? pick.lo_t : pick.hi_t;
      end else if (pick.lo_have) begin
         thr = pick.lo_t;
      end else begin
         thr = pick.hi_t;
      end
      res.dup = dup_ff;
      if (!mx_ff.have) begin
         res.cls = CLASS_NONE;
      end else begin
         res.cls = (thr > q_vph) ? CLASS_PION : CLASS_PROTON;
      end
   end

endmodule

[rtl/core/track_particle_classifier.sv]
// ----------------------------------------------------------------------------
// track_particle_classifier - pulse-height threshold table and track classifier
// Loads and clears a ring of threshold points and labels tracks as
// unclassified, muon, pion or proton.
// ----------------------------------------------------------------------------
// flow: clear, unused command and classify without lookup go from idle to
//   reply; load and table lookup pass through scan and finish before reply
// requests: one at a time; each load or lookup turns the point ring once,
//   shifting every point past the head, before the next request is taken
// reset: synchronous, clears every point's valid bit and the entry count at
//   once; the response slot empties and the block is ready the next cycle
module track_particle_classifier
   import tpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic [15:0]        req_entry_angle_max,
   input  logic [15:0]        req_entry_momentum,
   input  logic [15:0]        req_entry_vph_threshold,
   input  logic [15:0]        req_track_angle,
   input  logic signed [16:0] req_track_momentum,
   input  logic [15:0]        req_track_pulse_height,
   input  logic [15:0]        req_chain_id,
   input  logic               req_prior_muon,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_particle_class,
   output logic [1:0]         rsp_status,
   output logic [8:0]         rsp_entries_held
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_REPLY
   } state_type;

   state_type state_ff, state_in;

   // request fields held for the duration of the work
   logic [1:0]       q_cmd_ff,  q_cmd_in;
   logic [BIN_W-1:0] q_bin_ff,  q_bin_in;
   logic [VAL_W-1:0] q_mom_ff,  q_mom_in;
   logic [VAL_W-1:0] q_thr_ff,  q_thr_in;
   logic [VAL_W-1:0] q_vph_ff,  q_vph_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] step_ff,  step_in;
   logic [1:0]       pend_class_ff, pend_class_in;
   logic [1:0]       pend_status_ff, pend_status_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_class_ff, rsp_class_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [8:0]       rsp_held_ff, rsp_held_in;

   logic             accept;
   logic             is_muon, out_of_range, is_empty, is_full;
   logic             wr_go, clr_go, scanning;
   scan_ctl_type     scan_ctl;
   scan_res_type     scan_res;
   point_type        wr_point;
   point_type        cell_q [TABLE_DEPTH];

   assign accept = req_valid && req_ready;

   // track screening straight from the request ports
   assign is_muon      = (req_chain_id == '0) || req_prior_muon;
   assign out_of_range = (req_track_momentum < 17'sd0) ||
                         (req_track_momentum > MOM_LIMIT) ||
                         (req_track_momentum == MOM_MISSING);
   assign is_empty     = (count_ff == '0);
   assign is_full      = (count_ff == CNT_W'(TABLE_DEPTH));

   always_comb begin
      state_in       = state_ff;
      q_cmd_in       = q_cmd_ff;
      q_bin_in       = q_bin_ff;
      q_mom_in       = q_mom_ff;
      q_thr_in       = q_thr_ff;
      q_vph_in       = q_vph_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      pend_class_in  = pend_class_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_class_in   = rsp_class_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_held_in    = rsp_held_ff;
      req_ready      = 1'b0;
      wr_go          = 1'b0;
      clr_go         = 1'b0;
      scan_ctl       = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               q_cmd_in       = req_cmd;
               q_thr_in       = req_entry_vph_threshold;
               q_vph_in       = req_track_pulse_height;
               step_in        = '0;
               scan_ctl.start = 1'b1;
               pend_class_in  = CLASS_NONE;
               pend_status_in = STATUS_OK;
               if (req_cmd == CMD_LOAD) begin
                  q_bin_in = bin_of(req_entry_angle_max);
                  q_mom_in = req_entry_momentum;
               end else begin
                  q_bin_in = bin_of(req_track_angle);
                  q_mom_in = req_track_momentum[VAL_W-1:0];
               end
               case (req_cmd)
                  CMD_LOAD: begin
                     state_in = ST_SCAN;
                  end
                  CMD_CLEAR: begin
                     // every point drops at once
                     clr_go   = 1'b1;
                     count_in = '0;
                     state_in = ST_REPLY;
                  end
                  CMD_CLASSIFY: begin
                     pend_status_in = is_empty ? STATUS_EMPTY : STATUS_OK;
                     if (is_muon) begin
                        pend_class_in = CLASS_MUON;
                        state_in      = ST_REPLY;
                     end else if (out_of_range || is_empty) begin
                        state_in = ST_REPLY;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ST_REPLY;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // one point leaves the ring head per cycle, the ring turns once
            scan_ctl.step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               step_in  = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_REPLY;
            if (q_cmd_ff == CMD_LOAD) begin
               if (scan_res.dup) begin
                  pend_status_in = STATUS_OK;
               end else if (is_full) begin
                  pend_status_in = STATUS_FULL;
               end else begin
                  wr_go    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end else begin
               pend_class_in = scan_res.cls;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_class_in  = pend_class_ff;
               rsp_status_in = pend_status_ff;
               rsp_held_in   = 9'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff       <= state_in;
      q_cmd_ff       <= q_cmd_in;
      q_bin_ff       <= q_bin_in;
      q_mom_ff       <= q_mom_in;
      q_thr_ff       <= q_thr_in;
      q_vph_ff       <= q_vph_in;
      count_ff       <= count_in;
      step_ff        <= step_in;
      pend_class_ff  <= pend_class_in;
      pend_status_ff <= pend_status_in;
      rsp_valid_ff   <= rsp_valid_in;
      rsp_class_ff   <= rsp_class_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_held_ff    <= rsp_held_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_particle_class = rsp_class_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entries_held   = rsp_held_ff;

   // new point goes to the first free slot once the ring is back home
   assign scanning       = (state_ff == ST_SCAN);
   assign wr_point.valid = 1'b1;
   assign wr_point.bin   = q_bin_ff;
   assign wr_point.mom   = q_mom_ff;
   assign wr_point.thr   = q_thr_ff;

   // ring of cells: each takes its upper neighbour, the last wraps to the head
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      cell_ctl_type ctl;
      point_type    nxt;

      assign ctl.shift = scanning;
      assign ctl.clr   = clr_go;
      assign ctl.wr    = wr_go && (count_ff[IDX_W-1:0] == IDX_W'(i));

      if (i == TABLE_DEPTH - 1) begin : g_wrap
         assign nxt = cell_q[0];
      end else begin : g_link
         assign nxt = cell_q[i+1];
      end

      tpc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .shift_in (nxt),
         .wr_point (wr_point),
         .point    (cell_q[i])
      );
   end

   // search unit watches the head of the ring
   tpc_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .point (cell_q[0]),
      .q_bin (q_bin_ff),
      .q_mom (q_mom_ff),
      .q_vph (q_vph_ff),
      .res   (scan_res)
   );

endmodule

[rtl/core/tpc_checker.sv]
// ----------------------------------------------------------------------------
// tpc_checker - port-level checks for the track particle classifier
// Watches the response channel against the request channel over time.
// ----------------------------------------------------------------------------
module tpc_checker
   import tpc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_particle_class,
   input logic [1:0]         rsp_status,
   input logic [8:0]         rsp_entries_held
);

   // a stalled response holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_particle_class) &&
      $stable(rsp_status) && $stable(rsp_entries_held))
      else $error("response changed while stalled");

   // empty table is only reported with nothing held and no pion or proton
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |->
      rsp_entries_held == '0 &&
      (rsp_particle_class == CLASS_NONE || rsp_particle_class == CLASS_MUON))
      else $error("empty status with inconsistent response");

   // a dropped point means a full table and no class
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |->
      rsp_entries_held == 9'(TABLE_DEPTH) && rsp_particle_class == CLASS_NONE)
      else $error("full status with inconsistent response");

   // a request is never answered in the cycle after it is taken
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response appeared too early");

endmodule

bind track_particle_classifier tpc_checker u_tpc_checker (.*);
